// ===== sv/sbc_packet_ingress_queue_unit_macros.svh =====
// Assertion macros for the packet ingress queue.
// Included by modules that assert; expects clk_i and rst_ni in scope.
`ifndef SBC_PACKET_INGRESS_QUEUE_UNIT_MACROS_SVH
`define SBC_PACKET_INGRESS_QUEUE_UNIT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define SBCQ_ASSERT_HOLDS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// whenever ante holds, cons holds in the same cycle
`define SBCQ_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== sv/sbcq_pkg.sv =====
// Shared types, constants and codes for the packet ingress queue.
// No dependencies; used by sbcq_rx, sbcq_ring and the top level.
package sbcq_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int QUEUE_DEPTH  = 8;

  // one extra physical slot: the staging slot rotates with the tail
  localparam int NSLOT     = QUEUE_DEPTH + 1;
  localparam int SLOT_W    = $clog2(NSLOT);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W     = $clog2(PACKET_BYTES + 2);
  localparam int OFS_W     = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int PAY_DEPTH = NSLOT * PACKET_BYTES;
  localparam int PAY_AW    = $clog2(PAY_DEPTH);
  localparam int LEN_W     = 7;

  localparam logic [7:0] HDR_RSVD_MASK = 8'hF0;
  localparam logic [7:0] HDR_FRAME_MASK = 8'h0F;

  typedef enum logic {
    MODE_RX  = 1'b0,
    MODE_POP = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    KIND_RX_STATUS = 2'd0,
    KIND_POP_DATA  = 2'd1,
    KIND_POP_EMPTY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_INVALID  = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic {
    POP_IDLE   = 1'b0,
    POP_STREAM = 1'b1
  } pop_state_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] seq_number;
    logic [31:0] time_stamp;
    logic [7:0]  byte_in;
    logic        last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [15:0]      out_sequence;
    logic [31:0]      out_timestamp;
    logic [LEN_W-1:0] payload_length;
    logic [3:0]       frames;
    logic             gap_flag;
    logic [7:0]       byte_out;
    logic             final_res;
    logic [31:0]      drop_total;
  } out_word_t;

  // per-slot header, 60 bits
  typedef struct packed {
    logic [15:0]      seq;
    logic [31:0]      ts;
    logic [LEN_W-1:0] len;
    logic [3:0]       frames;
    logic             gap;
  } slot_hdr_t;

  // receive side -> ring: payload byte write into staging slot, commit
  typedef struct packed {
    logic             wr_en;
    logic [OFS_W-1:0] wr_ofs;
    logic [7:0]       wr_data;
    logic             commit;
    slot_hdr_t        hdr;
  } rx_cmd_t;

  typedef struct packed {
    logic busy;
    logic empty;
    logic full;
  } ring_stat_t;

  typedef struct packed {
    logic       valid;
    slot_hdr_t  hdr;
    logic [7:0] data;
    logic       last;
  } ring_strm_t;

endpackage

// ===== sv/sbcq_rx.sv =====
// Receive framing: byte position, header check, sequence tracking, drops.
// Depends on sbcq_pkg; drives payload writes and commits into sbcq_ring.
module sbcq_rx (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_en_i,
  input  sbcq_pkg::in_word_t  in_word_i,
  input  logic                full_i,
  output sbcq_pkg::rx_cmd_t   rx_cmd_o,
  output logic                res_valid_o,
  output sbcq_pkg::out_word_t res_word_o,
  output logic [31:0]         drop_count_o
);

  logic [sbcq_pkg::POS_W-1:0] pos_q, pos_d, pos_adv, plen;
  logic [7:0]  hdr_byte_q, hdr_byte_d, hdr_now;
  logic        overrun_q, overrun_d, ovr_now;
  logic        seen_q, seen_d;
  logic        pend_q, pend_d;
  logic [15:0] next_exp_q, next_exp_d;
  logic [31:0] drop_q, drop_d;
  logic        done, bad, gap;
  sbcq_pkg::status_e status;

  always_comb begin
    hdr_now = (pos_q == '0) ? in_word_i.byte_in : hdr_byte_q;
    ovr_now = overrun_q | (pos_q > sbcq_pkg::POS_W'(sbcq_pkg::PACKET_BYTES));
    pos_adv = (pos_q <= sbcq_pkg::POS_W'(sbcq_pkg::PACKET_BYTES)) ? pos_q + 1'b1 : pos_q;
    plen    = pos_adv - 1'b1;
    bad     = (plen == '0) || ovr_now || ((hdr_now & sbcq_pkg::HDR_RSVD_MASK) != 8'h00)
              || ((hdr_now & sbcq_pkg::HDR_FRAME_MASK) == 8'h00);
    gap     = seen_q && (in_word_i.seq_number != next_exp_q);
    done    = rx_en_i && in_word_i.last_byte;

    pos_d      = pos_q;
    hdr_byte_d = hdr_byte_q;
    overrun_d  = overrun_q;
    seen_d     = seen_q;
    pend_d     = pend_q;
    next_exp_d = next_exp_q;
    drop_d     = drop_q;
    status     = sbcq_pkg::ST_ACCEPTED;

    rx_cmd_o.wr_en   = rx_en_i && (pos_q != '0)
                       && (pos_q <= sbcq_pkg::POS_W'(sbcq_pkg::PACKET_BYTES));
    rx_cmd_o.wr_ofs  = sbcq_pkg::OFS_W'(pos_q - 1'b1);
    rx_cmd_o.wr_data = in_word_i.byte_in;
    rx_cmd_o.commit  = 1'b0;
    rx_cmd_o.hdr.seq    = in_word_i.seq_number;
    rx_cmd_o.hdr.ts     = in_word_i.time_stamp;
    rx_cmd_o.hdr.len    = sbcq_pkg::LEN_W'(plen);
    rx_cmd_o.hdr.frames = hdr_now[3:0];
    rx_cmd_o.hdr.gap    = gap | pend_q;

    if (rx_en_i) begin
      if (pos_q == '0) begin
        hdr_byte_d = in_word_i.byte_in;
      end
      pos_d     = pos_adv;
      overrun_d = ovr_now;
    end

    if (done) begin
      pos_d     = '0;
      overrun_d = 1'b0;
      if (bad) begin
        drop_d = drop_q + 32'd1;
        pend_d = 1'b1;
        status = sbcq_pkg::ST_INVALID;
      end else begin
        next_exp_d = in_word_i.seq_number + 16'd1;
        seen_d     = 1'b1;
        if (full_i) begin
          drop_d = drop_q + 32'd1;
          pend_d = 1'b1;
          status = sbcq_pkg::ST_FULL;
        end else begin
          rx_cmd_o.commit = 1'b1;
          pend_d = 1'b0;
        end
      end
    end

    res_valid_o               = done;
    res_word_o                = '0;
    res_word_o.kind           = sbcq_pkg::KIND_RX_STATUS;
    res_word_o.status         = status;
    res_word_o.final_res      = 1'b1;
    res_word_o.drop_total     = drop_d;
  end

  assign drop_count_o = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      hdr_byte_q <= '0;
      overrun_q  <= 1'b0;
      seen_q     <= 1'b0;
      pend_q     <= 1'b0;
      next_exp_q <= '0;
      drop_q     <= '0;
    end else begin
      pos_q      <= pos_d;
      hdr_byte_q <= hdr_byte_d;
      overrun_q  <= overrun_d;
      seen_q     <= seen_d;
      pend_q     <= pend_d;
      next_exp_q <= next_exp_d;
      drop_q     <= drop_d;
    end
  end

endmodule

// ===== sv/sbcq_ring.sv =====
// Slot ring: payload and header memories, head/tail/count, pop streamer.
// Depends on sbcq_pkg and the assertion macro header.
`include "sbc_packet_ingress_queue_unit_macros.svh"

module sbcq_ring (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbcq_pkg::rx_cmd_t    rx_cmd_i,
  input  logic                 pop_start_i,
  input  logic                 take_i,
  output sbcq_pkg::ring_stat_t stat_o,
  output sbcq_pkg::ring_strm_t strm_o
);

  // tail slot doubles as the staging slot; NSLOT = depth + 1 keeps it free
  logic [7:0]          pay_mem [sbcq_pkg::PAY_DEPTH];
  sbcq_pkg::slot_hdr_t hdr_mem [sbcq_pkg::NSLOT];

  logic [sbcq_pkg::SLOT_W-1:0] head_q, head_d, tail_q, tail_d;
  logic [sbcq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [sbcq_pkg::OFS_W-1:0]  cur_q, cur_d, rd_ofs;
  sbcq_pkg::pop_state_e        state_q, state_d;
  sbcq_pkg::slot_hdr_t         hdr_rd_q;
  logic [7:0]                  pay_rd_q;
  logic                        pay_re, last, pop_done;
  logic [sbcq_pkg::PAY_AW-1:0] pay_wa, pay_ra;
  logic [sbcq_pkg::SLOT_W:0]   tail_sum, tail_exp;

  function automatic logic [sbcq_pkg::PAY_AW-1:0] pay_addr(
    input logic [sbcq_pkg::SLOT_W-1:0] slot,
    input logic [sbcq_pkg::OFS_W-1:0]  ofs
  );
    return sbcq_pkg::PAY_AW'(slot) * sbcq_pkg::PAY_AW'(sbcq_pkg::PACKET_BYTES)
           + sbcq_pkg::PAY_AW'(ofs);
  endfunction

  function automatic logic [sbcq_pkg::SLOT_W-1:0] slot_inc(
    input logic [sbcq_pkg::SLOT_W-1:0] s
  );
    return (s == sbcq_pkg::SLOT_W'(sbcq_pkg::NSLOT - 1)) ? '0 : s + 1'b1;
  endfunction

  always_comb begin
    last     = (sbcq_pkg::LEN_W'(cur_q) + sbcq_pkg::LEN_W'(1)) == hdr_rd_q.len;
    state_d  = state_q;
    cur_d    = cur_q;
    pay_re   = 1'b0;
    rd_ofs   = '0;
    pop_done = 1'b0;
    case (state_q)
      sbcq_pkg::POP_IDLE: begin
        if (pop_start_i) begin
          pay_re  = 1'b1;
          cur_d   = '0;
          state_d = sbcq_pkg::POP_STREAM;
        end
      end
      sbcq_pkg::POP_STREAM: begin
        if (take_i) begin
          if (last) begin
            pop_done = 1'b1;
            state_d  = sbcq_pkg::POP_IDLE;
          end else begin
            pay_re = 1'b1;
            rd_ofs = cur_q + 1'b1;
            cur_d  = cur_q + 1'b1;
          end
        end
      end
      default: state_d = sbcq_pkg::POP_IDLE;
    endcase

    pay_wa = pay_addr(tail_q, rx_cmd_i.wr_ofs);
    pay_ra = pay_addr(head_q, rd_ofs);

    head_d  = pop_done ? slot_inc(head_q) : head_q;
    tail_d  = rx_cmd_i.commit ? slot_inc(tail_q) : tail_q;
    count_d = count_q + sbcq_pkg::CNT_W'(rx_cmd_i.commit) - sbcq_pkg::CNT_W'(pop_done);

    stat_o.busy  = (state_q == sbcq_pkg::POP_STREAM);
    stat_o.empty = (count_q == '0);
    stat_o.full  = (count_q >= sbcq_pkg::CNT_W'(sbcq_pkg::QUEUE_DEPTH));

    strm_o.valid = (state_q == sbcq_pkg::POP_STREAM);
    strm_o.hdr   = hdr_rd_q;
    strm_o.data  = pay_rd_q;
    strm_o.last  = last;

    tail_sum = (sbcq_pkg::SLOT_W + 1)'(head_q) + (sbcq_pkg::SLOT_W + 1)'(count_q);
    tail_exp = (tail_sum >= (sbcq_pkg::SLOT_W + 1)'(sbcq_pkg::NSLOT))
               ? tail_sum - (sbcq_pkg::SLOT_W + 1)'(sbcq_pkg::NSLOT) : tail_sum;
  end

  // memories: one write port, one registered read port each
  always_ff @(posedge clk_i) begin
    if (rx_cmd_i.wr_en) begin
      pay_mem[pay_wa] <= rx_cmd_i.wr_data;
    end
    if (pay_re) begin
      pay_rd_q <= pay_mem[pay_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_cmd_i.commit) begin
      hdr_mem[tail_q] <= rx_cmd_i.hdr;
    end
    if (pop_start_i) begin
      hdr_rd_q <= hdr_mem[head_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbcq_pkg::POP_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      cur_q   <= cur_d;
    end
  end

  `SBCQ_ASSERT_HOLDS(a_count_range, count_q <= sbcq_pkg::CNT_W'(sbcq_pkg::QUEUE_DEPTH), "entry count above depth")
  `SBCQ_ASSERT_HOLDS(a_tail_track, tail_q == sbcq_pkg::SLOT_W'(tail_exp), "tail out of step with head plus count")
  `SBCQ_ASSERT_IMPLIES(a_stream_nonempty, state_q == sbcq_pkg::POP_STREAM, count_q != '0, "streaming from empty ring")
  `SBCQ_ASSERT_IMPLIES(a_commit_room, rx_cmd_i.commit, !stat_o.full, "commit into full ring")

endmodule

// ===== sv/sbc_packet_ingress_queue_unit.sv =====
// Top level of the packet ingress queue: handshakes and output register.
// Depends on sbcq_pkg, sbcq_rx and sbcq_ring.
//
//  channel | dir | handshake              | word
//  --------+-----+------------------------+----------------------
//  in      | in  | in_valid_i / in_stall_o   | sbcq_pkg::in_word_t
//  out     | out | out_valid_o / out_stall_i | sbcq_pkg::out_word_t
//
// Receive bytes: one per cycle unless stalled; only packet ends yield a word.
// Pop: once accepted, the ring streams one payload word per cycle while
//   the output is not stalled, from the payload RAM's single registered
//   read port, stalling the input; a pop on an empty ring yields one word.
// Reset clears pointers, counters and framing state; memories keep garbage.
// A stalled output holds its word; while no pop streams, input flows unless
//   the next item would need the output register (last byte or pop).
module sbc_packet_ingress_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sbcq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sbcq_pkg::out_word_t out_word_o
);

  sbcq_pkg::rx_cmd_t    rx_cmd;
  sbcq_pkg::ring_stat_t ring_stat;
  sbcq_pkg::ring_strm_t ring_strm;
  sbcq_pkg::out_word_t  rx_res, out_word_q, out_word_d;
  logic                 rx_res_valid;
  logic [31:0]          drop_count;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free, needs_out, in_acc, rx_en, pop_acc, pop_start;

  // output slot frees when empty or being taken this edge
  assign out_free  = !out_valid_q || !out_stall_i;
  assign needs_out = (in_word_i.mode == sbcq_pkg::MODE_POP) || in_word_i.last_byte;
  // ring streaming blocks input; stalled output blocks only word-producing items
  assign in_stall_o = ring_stat.busy || (needs_out && !out_free);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign rx_en     = in_acc && (in_word_i.mode == sbcq_pkg::MODE_RX);
  assign pop_acc   = in_acc && (in_word_i.mode == sbcq_pkg::MODE_POP);
  assign pop_start = pop_acc && !ring_stat.empty;

  sbcq_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_en_i      (rx_en),
    .in_word_i    (in_word_i),
    .full_i       (ring_stat.full),
    .rx_cmd_o     (rx_cmd),
    .res_valid_o  (rx_res_valid),
    .res_word_o   (rx_res),
    .drop_count_o (drop_count)
  );

  sbcq_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_cmd_i    (rx_cmd),
    .pop_start_i (pop_start),
    .take_i      (out_free),
    .stat_o      (ring_stat),
    .strm_o      (ring_strm)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (rx_res_valid) begin
      out_valid_d = 1'b1;
      out_word_d  = rx_res;
    end else if (pop_acc && ring_stat.empty) begin
      out_valid_d           = 1'b1;
      out_word_d            = '0;
      out_word_d.kind       = sbcq_pkg::KIND_POP_EMPTY;
      out_word_d.final_res  = 1'b1;
      out_word_d.drop_total = drop_count;
    end else if (ring_strm.valid && out_free) begin
      out_valid_d               = 1'b1;
      out_word_d.kind           = sbcq_pkg::KIND_POP_DATA;
      out_word_d.status         = sbcq_pkg::ST_ACCEPTED;
      out_word_d.out_sequence   = ring_strm.hdr.seq;
      out_word_d.out_timestamp  = ring_strm.hdr.ts;
      out_word_d.payload_length = ring_strm.hdr.len;
      out_word_d.frames         = ring_strm.hdr.frames;
      out_word_d.gap_flag       = ring_strm.hdr.gap;
      out_word_d.byte_out       = ring_strm.data;
      out_word_d.final_res      = ring_strm.last;
      out_word_d.drop_total     = drop_count;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
